// File: src/asd_pkg.sv
// Shared types, constants and width helpers for the accelerometer stillness detector.
`timescale 1ns / 1ps

package asd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int LEN_W       = 7;
  localparam int THRESH_W    = 26;
  localparam int TIMEOUT_W   = 20;
  localparam int CFG_W       = 26;
  localparam int CFG_IDX_W   = 2;
  localparam int FRAC_BITS   = 8;
  localparam int DEV_SUM_W   = 26;
  localparam logic [DEV_SUM_W-1:0] DEV_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STILL_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_SAMPLES = 2'd2;

  localparam logic [LEN_W-1:0]     WINDOW_LENGTH_RST   = 7'd32;
  localparam logic [THRESH_W-1:0]  STILL_THRESHOLD_RST = 26'd2560;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_SAMPLES_RST = 20'd2000;

  localparam int AXES = 3;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;
  } sample_word_t;

  typedef struct packed {
    logic [DEV_SUM_W-1:0] deviation_sum;
    logic                 window_full;
    logic                 is_still;
    logic                 timed_out;
    logic                 wait_done;
  } result_word_t;

  typedef struct packed {
    logic upd;
    logic drop;
    logic calc;
    logic ack;
    logic clear;
  } lane_ctl_t;

  // Width of the numerator fed to the divider: (n*Q - S*S) << 16, rounded up to even.
  function automatic int num_width(int window_max);
    int slot_w;
    int sum_w;
    int sq_w;
    int d_w;
    slot_w = $clog2(window_max);
    sum_w  = SAMPLE_BITS + slot_w + 1;
    sq_w   = 2 * SAMPLE_BITS + slot_w;
    d_w    = (LEN_W + sq_w > 2 * sum_w) ? LEN_W + sq_w : 2 * sum_w;
    return ((d_w + 2 * FRAC_BITS + 1) / 2) * 2;
  endfunction

endpackage

// File: src/asd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module asd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/asd_lane.sv
// One axis lane: sample ring, running sums, serial divider and square root.
`timescale 1ns / 1ps

module asd_lane #(
  parameter int WINDOW_MAX = 64,
  localparam int SLOT_W = $clog2(WINDOW_MAX),
  localparam int NUM_W  = asd_pkg::num_width(WINDOW_MAX),
  localparam int DEV_W  = NUM_W / 2
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  asd_pkg::lane_ctl_t                    ctl,
  input  logic signed [asd_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [SLOT_W-1:0]                     slot,
  input  logic [asd_pkg::LEN_W-1:0]             n,
  output logic [DEV_W-1:0]                      dev,
  output logic                                  done
);
  import asd_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + SLOT_W + 1;
  localparam int SQ_W  = 2 * SAMPLE_BITS + SLOT_W;
  localparam int D_W   = (LEN_W + SQ_W > 2 * SUM_W) ? LEN_W + SQ_W : 2 * SUM_W;
  localparam int DEN_W = 2 * LEN_W;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int PROD_W = 2 * SAMPLE_BITS;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_MUL  = 3'd1;
  localparam logic [2:0] PH_SUB  = 3'd2;
  localparam logic [2:0] PH_DIV  = 3'd3;
  localparam logic [2:0] PH_SQRT = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;

  logic [2:0] phase, phase_next;
  logic [CNT_W-1:0] cnt;

  logic signed [SUM_W-1:0] sum;
  logic [SQ_W-1:0] sq;
  logic [D_W-1:0] nq, ss;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] drem;
  logic [DEV_W-1:0] root;
  logic [DEV_W+1:0] srem;

  logic [SAMPLE_BITS-1:0] rdata;
  logic signed [SAMPLE_BITS-1:0] old;
  logic signed [PROD_W-1:0] old_prod, new_prod;
  logic signed [SUM_W-1:0] sum_next;
  logic [SQ_W-1:0] sq_next;
  logic [SUM_W-1:0] smag;
  logic [D_W-1:0] diff;
  logic [DEN_W:0] dtrial;
  logic [DEV_W+1:0] strial, sr2;

  asd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW_MAX)) u_ram (
    .clk   (clk),
    .we    (ctl.upd),
    .waddr (slot),
    .wdata (sample),
    .raddr (slot),
    .rdata (rdata)
  );

  always_comb begin
    old      = signed'(rdata);
    old_prod = old * old;
    new_prod = sample * sample;
    sum_next = sum - (ctl.drop ? SUM_W'(old) : SUM_W'(0)) + SUM_W'(sample);
    sq_next  = sq - (ctl.drop ? SQ_W'(unsigned'(old_prod)) : SQ_W'(0))
               + SQ_W'(unsigned'(new_prod));
    smag     = (sum < 0) ? unsigned'(-sum) : unsigned'(sum);
    diff     = (nq > ss) ? nq - ss : D_W'(0);
    dtrial   = {drem, num[NUM_W-1]};
    sr2      = {srem[DEV_W-1:0], num[NUM_W-1 -: 2]};
    strial   = {root, 2'b01};
  end

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE: if (ctl.calc) phase_next = PH_MUL;
      PH_MUL:  phase_next = PH_SUB;
      PH_SUB:  phase_next = PH_DIV;
      PH_DIV:  if (cnt == CNT_W'(NUM_W - 1)) phase_next = PH_SQRT;
      PH_SQRT: if (cnt == CNT_W'(DEV_W - 1)) phase_next = PH_DONE;
      PH_DONE: if (ctl.ack) phase_next = PH_IDLE;
      default: phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      sum   <= '0;
      sq    <= '0;
    end else begin
      phase <= phase_next;
      if (ctl.clear) begin
        sum <= '0;
        sq  <= '0;
      end else if (ctl.upd) begin
        sum <= sum_next;
        sq  <= sq_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (phase)
      PH_MUL: begin
        nq  <= D_W'(n) * D_W'(sq);
        ss  <= D_W'(smag) * D_W'(smag);
        den <= DEN_W'(n) * DEN_W'(n - LEN_W'(1));
      end
      PH_SUB: begin
        num  <= NUM_W'({diff, (2 * FRAC_BITS)'(0)});
        drem <= '0;
        cnt  <= '0;
      end
      PH_DIV: begin
        // Restoring divide: one quotient bit per cycle, shifted into num.
        if (dtrial >= {1'b0, den}) begin
          drem <= DEN_W'(dtrial - {1'b0, den});
          num  <= {num[NUM_W-2:0], 1'b1};
        end else begin
          drem <= dtrial[DEN_W-1:0];
          num  <= {num[NUM_W-2:0], 1'b0};
        end
        if (cnt == CNT_W'(NUM_W - 1)) begin
          cnt  <= '0;
          srem <= '0;
          root <= '0;
        end else begin
          cnt <= cnt + CNT_W'(1);
        end
      end
      PH_SQRT: begin
        // Digit-by-digit root, two radicand bits per cycle.
        num <= {num[NUM_W-3:0], 2'b00};
        if (sr2 >= strial) begin
          srem <= sr2 - strial;
          root <= {root[DEV_W-2:0], 1'b1};
        end else begin
          srem <= sr2;
          root <= {root[DEV_W-2:0], 1'b0};
        end
        cnt <= cnt + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign dev  = root;
  assign done = (phase == PH_DONE);

endmodule

// File: src/asd_merge.sv
// Merge of the three lane deviations, threshold test and the result register.
`timescale 1ns / 1ps

module asd_merge #(
  parameter int DEV_W = 31
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  logic [DEV_W-1:0]                dev [asd_pkg::AXES],
  input  logic                            full,
  input  logic                            tout,
  input  logic [asd_pkg::THRESH_W-1:0]    threshold,
  output logic                            done_now,
  output logic                            result_valid,
  input  logic                            result_stall,
  output asd_pkg::result_word_t           result
);
  import asd_pkg::*;

  localparam int TOT_W = DEV_W + 2;

  logic [TOT_W-1:0] total;
  logic [DEV_SUM_W-1:0] dsum;
  result_word_t word_next;

  always_comb begin
    total = TOT_W'(dev[0]) + TOT_W'(dev[1]) + TOT_W'(dev[2]);
    if (!full) begin
      dsum = '0;
    end else if (total > TOT_W'(DEV_MAX)) begin
      dsum = DEV_MAX;
    end else begin
      dsum = DEV_SUM_W'(total);
    end
    word_next.deviation_sum = dsum;
    word_next.window_full   = full;
    word_next.is_still      = full && (dsum <= threshold);
    word_next.timed_out     = tout;
    word_next.wait_done     = word_next.is_still || tout;
    done_now                = word_next.wait_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (load) begin
      result <= word_next;
    end
  end

endmodule

// File: src/accel_stillness_detector.sv
// Top level of the accelerometer stillness detector.
// Usage:
//   sample channel: one three-axis word per accept (sample_valid high, sample_stall low).
//   result channel: one result word per sample, same order (result_valid / result_stall).
//   cfg port: cfg_we with cfg_index 0 window length, 1 threshold, 2 timeout; write only
//   while idle. Writing the window length restarts the wait.
// Timing:
//   Before the window is full a sample passes the update and output states, and
//   its result is loaded into the output register when it leaves the output state.
//   Once full, each lane runs a multiply/subtract, a restoring divider of NUM_W
//   quotient bits (one quotient bit per cycle) and a square root of NUM_W/2 bits;
//   with WINDOW_MAX = 64, NUM_W = 62. One sample is in work at a time; sample_stall
//   is high from accept until its result enters the output register.
// Reset: clears counters, sums and the result valid; registers return to 32, 2560
//   and 2000. Ring entries need no clearing: only entries written in the current
//   wait are read.
// Stall: a stalled result holds; the next sample is still taken and worked on, and
//   its result waits for the output register to free.
`timescale 1ns / 1ps

module accel_stillness_detector #(
  parameter int WINDOW_MAX = 64,
  parameter int COUNT_BITS = 20
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  asd_pkg::sample_word_t           sample,
  output logic                            result_valid,
  input  logic                            result_stall,
  output asd_pkg::result_word_t           result,
  input  logic                            cfg_we,
  input  logic [asd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [asd_pkg::CFG_W-1:0]       cfg_data
);
  import asd_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW_MAX);
  localparam int NUM_W  = num_width(WINDOW_MAX);
  localparam int DEV_W  = NUM_W / 2;
  localparam int CMP_W  = (LEN_W > SLOT_W + 1) ? LEN_W : SLOT_W + 1;
  localparam int TW     = (COUNT_BITS > TIMEOUT_W) ? COUNT_BITS : TIMEOUT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_CALC = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state, state_next;
  logic [LEN_W-1:0] window_length;
  logic [THRESH_W-1:0] still_threshold;
  logic [TIMEOUT_W-1:0] timeout_samples;
  logic [SLOT_W-1:0] slot, slot_next;
  logic [COUNT_BITS-1:0] count, count_next;
  logic full;
  sample_word_t held;
  logic [LEN_W-1:0] n;
  logic [CMP_W-1:0] slot_inc;
  lane_ctl_t ctl;
  logic [DEV_W-1:0] dev [AXES];
  logic [AXES-1:0] lane_done;
  logic signed [SAMPLE_BITS-1:0] lane_sample [AXES];
  logic load, done_now, tout, cfg_len_wr;

  always_comb begin
    if (window_length < LEN_W'(2)) begin
      n = LEN_W'(2);
    end else if (32'(window_length) > 32'(WINDOW_MAX)) begin
      n = LEN_W'(WINDOW_MAX);
    end else begin
      n = window_length;
    end
  end

  assign cfg_len_wr = cfg_we && (cfg_index == REG_WINDOW_LENGTH);
  assign sample_stall = (state != ST_IDLE);
  assign load = (state == ST_OUT) && (!result_valid || !result_stall);
  assign tout = TW'(count) >= TW'(timeout_samples);

  always_comb begin
    slot_inc   = CMP_W'(slot) + CMP_W'(1);
    slot_next  = (slot_inc >= CMP_W'(n)) ? '0 : SLOT_W'(slot_inc);
    count_next = (count == '1) ? count : count + COUNT_BITS'(1);
  end

  always_comb begin
    ctl.upd   = (state == ST_UPD);
    ctl.drop  = count >= COUNT_BITS'(n);
    ctl.calc  = (state == ST_UPD) && (count_next > COUNT_BITS'(n));
    ctl.ack   = load;
    ctl.clear = cfg_len_wr || (load && done_now);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (sample_valid) state_next = ST_UPD;
      ST_UPD:  state_next = ctl.calc ? ST_CALC : ST_OUT;
      ST_CALC: if (&lane_done) state_next = ST_OUT;
      ST_OUT:  if (load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      window_length   <= WINDOW_LENGTH_RST;
      still_threshold <= STILL_THRESHOLD_RST;
      timeout_samples <= TIMEOUT_SAMPLES_RST;
      slot            <= '0;
      count           <= '0;
      full            <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW_LENGTH:   window_length   <= cfg_data[LEN_W-1:0];
          REG_STILL_THRESHOLD: still_threshold <= cfg_data[THRESH_W-1:0];
          REG_TIMEOUT_SAMPLES: timeout_samples <= cfg_data[TIMEOUT_W-1:0];
          default: begin
          end
        endcase
      end
      if (ctl.clear) begin
        slot  <= '0;
        count <= '0;
      end else if (state == ST_UPD) begin
        slot  <= slot_next;
        count <= count_next;
        full  <= ctl.calc;
      end
    end
  end

  // Hold the word while its lanes work on it.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && sample_valid) begin
      held <= sample;
    end
  end

  assign lane_sample[0] = held.accel_x;
  assign lane_sample[1] = held.accel_y;
  assign lane_sample[2] = held.accel_z;

  for (genvar a = 0; a < AXES; a++) begin : g_lane
    asd_lane #(.WINDOW_MAX(WINDOW_MAX)) u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .sample (lane_sample[a]),
      .slot   (slot),
      .n      (n),
      .dev    (dev[a]),
      .done   (lane_done[a])
    );
  end

  asd_merge #(.DEV_W(DEV_W)) u_merge (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .dev          (dev),
    .full         (full),
    .tout         (tout),
    .threshold    (still_threshold),
    .done_now     (done_now),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// File: src/asd_checker.sv
// Port-level checker for the stillness detector, bound to the top level.
`timescale 1ns / 1ps

module asd_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  result_valid,
  input logic                  result_stall,
  input asd_pkg::result_word_t result
);
  import asd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result word dropped or changed");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result valid straight after reset");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.window_full |-> result.deviation_sum == '0 && !result.is_still)
    else $error("deviation reported before the window filled");

  a_done: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.wait_done == (result.is_still || result.timed_out))
    else $error("wait_done disagrees with still and timeout flags");

endmodule

bind accel_stillness_detector asd_checker u_asd_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
